### sv/binned_mean_1d_assert.svh
// Assertion macros shared by the binned mean block.
`ifndef BINNED_MEAN_1D_ASSERT_SVH
`define BINNED_MEAN_1D_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BMD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BMD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### sv/bmd_pkg.sv
// Shared types and constants of the binned mean block.
`timescale 1ns / 1ps
package bmd_pkg;

  localparam int unsigned DAT_W = 32;
  localparam int unsigned CNT_W = 24;
  localparam int unsigned SUM_W = 56;
  localparam int unsigned CFG_W = 6;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned REPORT_MAX = 32;
  localparam logic [CNT_W-1:0] COUNT_SAT = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_DRAIN  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_CMP,
    OP_UPD
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [DAT_W-1:0]   x;
    logic [DAT_W-1:0]   f;
  } cell_ctl_t;

endpackage

### sv/binned_mean_1d.sv
// Top level of the binned mean block: control, cell chain and drain path.
//
//  channel   direction  handshake                  payload
//  command   in         start / busy               kind_i value_x_i value_f_i f_missing_i
//  config    in         cfg_valid_i / cfg_ready_o  cfg_data_i (breaks in use)
//  result    out        out_strobe_o, no stall     bin_index_o bin_count_o bin_mean_o
//                                                  mean_missing_o last_o
//
// A clear or a load runs in its own state; a sample runs a compare in every cell,
// then an update of the one bin hit; a dropped sample leaves the block idle. A drain
// reports each bin in turn; only a non-empty bin goes through the 56-step divider.
// Reset empties the table and all bins at once; breaks in use returns to 33.
// The receiver cannot stall: each result is shown for one cycle only.
`timescale 1ns / 1ps
`include "binned_mean_1d_assert.svh"
module binned_mean_1d import bmd_pkg::*; #(
  parameter int unsigned MAX_BREAKS = 33
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [DAT_W-1:0]  value_x_i,
  input  logic [DAT_W-1:0]  value_f_i,
  input  logic              f_missing_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              out_strobe_o,
  output logic [IDX_W-1:0]  bin_index_o,
  output logic [CNT_W-1:0]  bin_count_o,
  output logic [DAT_W-1:0]  bin_mean_o,
  output logic              mean_missing_o,
  output logic              last_o
);

  localparam int unsigned NB = MAX_BREAKS - 1;
  localparam int unsigned NW = $clog2(MAX_BREAKS + 1);
  localparam int unsigned CW = (NW > CFG_W + 1) ? NW : CFG_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_LOAD,
    S_CMP,
    S_UPD,
    S_DSEL,
    S_DST,
    S_DDIV
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] biu_q;
  logic [NW-1:0]    loaded_q;
  logic [DAT_W-1:0] x_q;
  logic [DAT_W-1:0] f_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] sum_q;
  logic             strobe_q;
  logic [IDX_W-1:0] oidx_q;
  logic [CNT_W-1:0] ocnt_q;
  logic [DAT_W-1:0] omean_q;
  logic             omiss_q;
  logic             olast_q;

  logic             accept;
  logic [CW-1:0]    n_eff;
  logic [CW-1:0]    nbins;
  logic             is_last;
  cell_ctl_t        ctl;
  logic [NW-1:0]    n_used;
  logic [CNT_W-1:0] cnt_sel;
  logic [SUM_W-1:0] sum_sel;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quot;
  logic [SUM_W-1:0] sum_mag;
  logic [DAT_W-1:0] q_lo;

  logic [DAT_W-1:0] brk_w [MAX_BREAKS];
  logic             gt_w  [MAX_BREAKS];
  logic             lt_w  [MAX_BREAKS];
  logic [CNT_W-1:0] cnt_w [MAX_BREAKS];
  logic [SUM_W-1:0] sum_w [MAX_BREAKS];

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  // effective breaks: least of register, loaded count and table size
  always_comb begin
    n_eff = CW'(biu_q);
    if (CW'(loaded_q) < n_eff) begin
      n_eff = CW'(loaded_q);
    end
    if (CW'(MAX_BREAKS) < n_eff) begin
      n_eff = CW'(MAX_BREAKS);
    end
    nbins = (n_eff > CW'(REPORT_MAX)) ? CW'(REPORT_MAX) : n_eff - CW'(1);
  end

  assign n_used  = n_eff[NW-1:0];
  assign is_last = (CW'(idx_q) + CW'(1)) == nbins;

  always_comb begin
    ctl.x = x_q;
    ctl.f = f_q;
    unique case (state_q)
      S_CLR:   ctl.op = OP_CLEAR;
      S_LOAD:  ctl.op = OP_LOAD;
      S_CMP:   ctl.op = OP_CMP;
      S_UPD:   ctl.op = OP_UPD;
      default: ctl.op = OP_NONE;
    endcase
  end

  // chain of cells: break value and compare flag pass left to right on load
  for (genvar k = 0; k < MAX_BREAKS; k++) begin : g_cell
    bmd_cell #(.IDX(k), .NW(NW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .loaded_i   (loaded_q),
      .n_used_i   (n_used),
      .prev_brk_i ((k == 0) ? '0 : brk_w[(k == 0) ? 0 : k - 1]),
      .prev_gt_i  ((k == 0) ? 1'b0 : gt_w[(k == 0) ? 0 : k - 1]),
      .next_lt_i  ((k == MAX_BREAKS - 1) ? 1'b0 : lt_w[(k == MAX_BREAKS - 1) ? k : k + 1]),
      .brk_o      (brk_w[k]),
      .gt_o       (gt_w[k]),
      .lt_o       (lt_w[k]),
      .cnt_o      (cnt_w[k]),
      .sum_o      (sum_w[k])
    );
  end

  // pick the bin under report
  always_comb begin
    cnt_sel = '0;
    sum_sel = '0;
    for (int unsigned k = 0; k < NB && k < REPORT_MAX; k++) begin
      if (idx_q == IDX_W'(k)) begin
        cnt_sel = cnt_w[k];
        sum_sel = sum_w[k];
      end
    end
  end

  assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;
  assign div_start = (state_q == S_DST) && (cnt_q != '0);
  assign q_lo      = div_quot[DAT_W-1:0];

  bmd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (sum_mag),
    .dsr_i   (cnt_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q <= CFG_W'(33);
    end else if (cfg_valid_i && cfg_ready_o) begin
      biu_q <= cfg_data_i;
    end
  end

  // hold the command payload for the cells, and the count and sum of the bin under report
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= value_x_i;
      f_q <= value_f_i;
    end
    if (state_q == S_DSEL) begin
      cnt_q <= cnt_sel;
      sum_q <= sum_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      loaded_q <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
      oidx_q   <= '0;
      ocnt_q   <= '0;
      omean_q  <= '0;
      omiss_q  <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (kind_e'(kind_i))
              KIND_CLEAR:  state_q <= S_CLR;
              KIND_LOAD: begin
                if (loaded_q != NW'(MAX_BREAKS)) begin
                  state_q <= S_LOAD;
                end
              end
              KIND_SAMPLE: begin
                if (!f_missing_i && n_eff >= CW'(2)) begin
                  state_q <= S_CMP;
                end
              end
              KIND_DRAIN: begin
                idx_q <= '0;
                if (n_eff >= CW'(2)) begin
                  state_q <= S_DSEL;
                end
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          loaded_q <= '0;
          state_q  <= S_IDLE;
        end
        S_LOAD: begin
          loaded_q <= loaded_q + NW'(1);
          state_q  <= S_IDLE;
        end
        S_CMP:  state_q <= S_UPD;
        S_UPD:  state_q <= S_IDLE;
        S_DSEL: state_q <= S_DST;
        S_DST: begin
          if (cnt_q == '0) begin
            // empty bin: report it missing without dividing
            strobe_q <= 1'b1;
            oidx_q   <= idx_q;
            ocnt_q   <= '0;
            omean_q  <= '0;
            omiss_q  <= 1'b1;
            olast_q  <= is_last;
            idx_q    <= idx_q + IDX_W'(1);
            state_q  <= is_last ? S_IDLE : S_DSEL;
          end else begin
            state_q <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (div_done) begin
            strobe_q <= 1'b1;
            oidx_q   <= idx_q;
            ocnt_q   <= cnt_q;
            omean_q  <= sum_q[SUM_W-1] ? DAT_W'(-q_lo) : q_lo;
            omiss_q  <= 1'b0;
            olast_q  <= is_last;
            idx_q    <= idx_q + IDX_W'(1);
            state_q  <= is_last ? S_IDLE : S_DSEL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_strobe_o   = strobe_q;
  assign bin_index_o    = oidx_q;
  assign bin_count_o    = ocnt_q;
  assign bin_mean_o     = omean_q;
  assign mean_missing_o = omiss_q;
  assign last_o         = olast_q;

  `BMD_ASSERT_NOW(a_table_bound, 1'b1, loaded_q <= NW'(MAX_BREAKS), "break table overfilled")
  `BMD_ASSERT_NOW(a_last_ends, out_strobe_o && last_o, !busy, "drain ran on after last bin")
  `BMD_ASSERT_NOW(a_missing_empty, out_strobe_o && mean_missing_o, bin_count_o == '0 && bin_mean_o == '0, "missing mean on a non-empty bin")
  `BMD_ASSERT_NEXT(a_div_in_drain, div_done, state_q == S_IDLE || state_q == S_DSEL, "divider result not consumed")

endmodule

### sv/bmd_cell.sv
// One cell of the chain: one break value and the bin that starts at it.
`timescale 1ns / 1ps
module bmd_cell import bmd_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned NW  = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [NW-1:0]     loaded_i,
  input  logic [NW-1:0]     n_used_i,
  input  logic [DAT_W-1:0]  prev_brk_i,
  input  logic              prev_gt_i,
  input  logic              next_lt_i,
  output logic [DAT_W-1:0]  brk_o,
  output logic              gt_o,
  output logic              lt_o,
  output logic [CNT_W-1:0]  cnt_o,
  output logic [SUM_W-1:0]  sum_o
);

  logic [DAT_W-1:0] brk_q;
  logic             lt_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] sum_q;
  logic             filled;
  logic             in_use;
  logic             hit;

  assign filled = NW'(IDX) < loaded_i;
  assign in_use = NW'(IDX) < n_used_i;
  assign gt_o   = filled && ($signed(brk_q) > $signed(ctl_i.x));
  // bin k takes the sample when break k is below it and break k+1 is not, if bin k is in use and not saturated
  assign hit    = lt_q && !next_lt_i && (NW'(IDX + 1) < n_used_i) && (cnt_q != COUNT_SAT);

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_LOAD) begin
      if (prev_gt_i) begin
        brk_q <= prev_brk_i;
      end else if (gt_o || (NW'(IDX) == loaded_i)) begin
        brk_q <= ctl_i.x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      unique case (ctl_i.op)
        OP_CLEAR: begin
          cnt_q <= '0;
          sum_q <= '0;
        end
        OP_CMP: lt_q <= in_use && ($signed(brk_q) < $signed(ctl_i.x));
        OP_UPD: begin
          if (hit) begin
            cnt_q <= cnt_q + CNT_W'(1);
            sum_q <= sum_q + {{(SUM_W-DAT_W){ctl_i.f[DAT_W-1]}}, ctl_i.f};
          end
        end
        default: ;
      endcase
    end
  end

  assign brk_o = brk_q;
  assign lt_o  = lt_q;
  assign cnt_o = cnt_q;
  assign sum_o = sum_q;

endmodule

### sv/bmd_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
`timescale 1ns / 1ps
module bmd_div import bmd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dvd_i,
  input  logic [CNT_W-1:0]  dsr_i,
  output logic              done_o,
  output logic [SUM_W-1:0]  quot_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              run_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [CNT_W:0]    shifted;
  logic              take;

  assign shifted = {rem_q, dvd_q[SUM_W-1]};
  assign take    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !run_q) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !run_q) begin
      dvd_q <= dvd_i;
      dsr_q <= dsr_i;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= take ? CNT_W'(shifted - {1'b0, dsr_q}) : shifted[CNT_W-1:0];
      dvd_q <= {dvd_q[SUM_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

### tb/testbench.sv
// Self-checking testbench of the binned mean block: directed and random requests.
`timescale 1ns / 1ps
module testbench;
  import bmd_pkg::*;

  localparam int unsigned N_BREAKS = 33;
  localparam int unsigned N_BINS = N_BREAKS - 1;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic [DAT_W-1:0] mean;
    logic             miss;
    logic             fin;
  } bin_report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        kind_i = KIND_CLEAR;
  logic [DAT_W-1:0]  value_x_i = '0;
  logic [DAT_W-1:0]  value_f_i = '0;
  logic              f_missing_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              out_strobe_o;
  logic [IDX_W-1:0]  bin_index_o;
  logic [CNT_W-1:0]  bin_count_o;
  logic [DAT_W-1:0]  bin_mean_o;
  logic              mean_missing_o;
  logic              last_o;

  binned_mean_1d #(.MAX_BREAKS(N_BREAKS)) DUT (.*);

  // Predictor state, kept alongside the block.
  logic signed [DAT_W-1:0] break_tab [N_BREAKS];
  int unsigned             n_loaded;
  logic [CFG_W-1:0]        in_use_reg;
  logic [CNT_W-1:0]        bin_cnt [N_BINS];
  logic signed [SUM_W-1:0] bin_sum [N_BINS];

  bin_report_t pending_reports [$];
  int unsigned n_errors;
  int unsigned n_requests;
  int unsigned n_reports;
  int unsigned n_binned;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Timeout: %0d reports still pending", pending_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic int unsigned breaks_effective();
    int unsigned n;
    n = in_use_reg;
    if (n > n_loaded) n = n_loaded;
    if (n > N_BREAKS) n = N_BREAKS;
    return n;
  endfunction

  function automatic void clear_predictor();
    n_loaded = 0;
    foreach (bin_cnt[i]) begin
      bin_cnt[i] = '0;
      bin_sum[i] = '0;
    end
    foreach (break_tab[i]) break_tab[i] = '0;
  endfunction

  // Work out the effect of one request and queue any reports it causes.
  function automatic void predict_bins(input kind_e k, input logic signed [DAT_W-1:0] x,
                                       input logic signed [DAT_W-1:0] f, input logic fm);
    int unsigned n;
    int unsigned below;
    int unsigned pos;
    int unsigned nb;
    logic signed [SUM_W-1:0] q;
    bin_report_t r;
    case (k)
      KIND_CLEAR: clear_predictor();
      KIND_LOAD: begin
        if (n_loaded < N_BREAKS) begin
          pos = n_loaded;
          // shift larger breaks up, equal ones stay ahead
          while (pos > 0 && break_tab[pos-1] > x) begin
            break_tab[pos] = break_tab[pos-1];
            pos--;
          end
          break_tab[pos] = x;
          n_loaded++;
        end
      end
      KIND_SAMPLE: begin
        n = breaks_effective();
        if (!fm && n >= 2) begin
          below = 0;
          for (int i = 0; i < n; i++) if (break_tab[i] < x) below++;
          if (below != 0 && below < n && bin_cnt[below-1] != COUNT_SAT) begin
            bin_cnt[below-1]++;
            bin_sum[below-1] += SUM_W'(f);
            n_binned++;
          end
        end
      end
      default: begin
        n = breaks_effective();
        if (n >= 2) begin
          nb = n - 1;
          if (nb > REPORT_MAX) nb = REPORT_MAX;
          for (int i = 0; i < nb; i++) begin
            r.idx = IDX_W'(i);
            r.cnt = bin_cnt[i];
            if (bin_cnt[i] != 0) begin
              q = bin_sum[i] / $signed({1'b0, bin_cnt[i]});
              r.mean = q[DAT_W-1:0];
              r.miss = 1'b0;
            end else begin
              r.mean = '0;
              r.miss = 1'b1;
            end
            r.fin = (i + 1 == nb);
            pending_reports.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // Check every strobed result against the oldest queued report.
  always @(posedge clk_i) begin
    bin_report_t w;
    if (rst_ni && out_strobe_o) begin
      n_reports++;
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result, bin", 64'(bin_index_o), 64'h0);
      end else begin
        w = pending_reports.pop_front();
        if (bin_index_o !== w.idx)
          report_mismatch("bin_index", 64'(bin_index_o), 64'(w.idx));
        if (bin_count_o !== w.cnt)
          report_mismatch("bin_count", 64'(bin_count_o), 64'(w.cnt));
        if (bin_mean_o !== w.mean)
          report_mismatch("bin_mean", 64'(bin_mean_o), 64'(w.mean));
        if (mean_missing_o !== w.miss)
          report_mismatch("mean_missing", 64'(mean_missing_o), 64'(w.miss));
        if (last_o !== w.fin) report_mismatch("last", 64'(last_o), 64'(w.fin));
      end
    end
  end

  // Send one request after a random gap; hold start until busy is low at an edge.
  // Start stays high after acceptance; drop it only when a gap or an idle spell follows.
  task automatic send_request(input kind_e k, input logic [DAT_W-1:0] x,
                              input logic [DAT_W-1:0] f, input logic fm, input bit gaps = 1);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    kind_i      <= k;
    value_x_i   <= x;
    value_f_i   <= f;
    f_missing_i <= fm;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_bins(k, x, f, fm);
    n_requests++;
  endtask

  // Let every queued report arrive, then the block settle.
  task automatic drain_pending();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_breaks_in_use(input logic [CFG_W-1:0] v);
    drain_pending();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    in_use_reg = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DAT_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Extremes, equal breaks, out-of-range samples, missing values, empty bins.
  task automatic test_directed();
    send_request(KIND_DRAIN, '0, '0, 1'b0);           // no breaks: no results
    send_request(KIND_LOAD, 32'h0001_0000, '0, 1'b0);
    send_request(KIND_SAMPLE, 32'h0002_0000, 32'h7FFF_FFFF, 1'b0);
    send_request(KIND_DRAIN, '0, '0, 1'b0);           // one break: still none
    send_request(KIND_LOAD, 32'h8000_0000, '0, 1'b0);
    send_request(KIND_LOAD, 32'h7FFF_FFFF, '0, 1'b0);
    send_request(KIND_LOAD, 32'h0001_0000, '0, 1'b0); // equal break
    send_request(KIND_SAMPLE, 32'h8000_0000, 32'h1234_5678, 1'b0); // on lowest break
    send_request(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_request(KIND_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0);
    send_request(KIND_SAMPLE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(KIND_SAMPLE, 32'h0001_0000, 32'h7FFF_FFFF, 1'b0);
    send_request(KIND_SAMPLE, 32'h0000_0000, 32'h0000_0005, 1'b1); // missing value
    send_request(KIND_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0);
    send_request(KIND_DRAIN, '0, '0, 1'b0);
    write_breaks_in_use(6'd2);                         // smallest two breaks only
    send_request(KIND_DRAIN, '0, '0, 1'b0);
    send_request(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(KIND_DRAIN, '0, '0, 1'b0);
  endtask

  // Fill the table past full, with the register at its widest setting.
  task automatic test_full_table();
    write_breaks_in_use(6'd63);
    send_request(KIND_CLEAR, '0, '0, 1'b0);
    for (int i = 0; i < N_BREAKS + 2; i++)
      send_request(KIND_LOAD, $urandom_range(0, 1) ? rand_word() : 32'(i) << 14, '0, 1'b0);
    send_request(KIND_DRAIN, '0, '0, 1'b0);
    send_request(KIND_CLEAR, '0, '0, 1'b0);
  endtask

  // Random episodes: maybe set the register, clear, load clustered breaks, stream samples, drain.
  task automatic test_random_episodes(input int unsigned budget);
    int unsigned nb;
    int unsigned ns;
    logic [DAT_W-1:0] lo;
    logic [DAT_W-1:0] span;
    int unsigned spent;
    spent = 0;
    while (spent < budget) begin
      case ($urandom_range(0, 3))
        0: write_breaks_in_use(6'd33);
        1: write_breaks_in_use(6'($urandom_range(2, 8)));
        2: write_breaks_in_use(6'($urandom_range(0, 63)));
        default: ;
      endcase
      send_request(KIND_CLEAR, rand_word(), rand_word(), 1'($urandom()));
      nb = $urandom_range(0, 5) == 0 ? $urandom_range(0, 3) : $urandom_range(2, 6);
      lo = $urandom_range(0, 1) ? 32'hFFF0_0000 + $urandom_range(0, 255) : rand_word();
      span = $urandom_range(1, 1 << 16);
      for (int i = 0; i < nb; i++)
        send_request(KIND_LOAD, lo + span * $urandom_range(0, 6), rand_word(), 1'($urandom()));
      ns = $urandom_range(4, 14);
      for (int i = 0; i < ns; i++)
        send_request(KIND_SAMPLE,
                     $urandom_range(0, 4) == 0 ? rand_word() : lo + $urandom_range(0, span * 7),
                     rand_word(), $urandom_range(0, 4) == 0);
      // noise: a late load, keeping the bins
      if ($urandom_range(0, 3) == 0)
        send_request(KIND_LOAD, rand_word(), '0, 1'b0);
      send_request(KIND_DRAIN, rand_word(), rand_word(), 1'($urandom()));
      if ($urandom_range(0, 2) == 0) drain_pending();  // sender holds off fully
      spent += nb + ns + 3;
    end
  endtask

  initial begin
    n_errors = 0;
    n_requests = 0;
    n_reports = 0;
    n_binned = 0;
    in_use_reg = 6'd33;
    clear_predictor();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random_episodes(100);
    write_breaks_in_use(6'd33);
    send_request(KIND_DRAIN, '0, '0, 1'b0, 0);
    drain_pending();
    $display("Covered %0d requests, %0d samples binned, %0d bin reports checked.",
             n_requests, n_binned, n_reports);
    if (n_errors == 0 && pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d reports missing", n_errors, pending_reports.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### binned_mean_1d.f
+incdir+sv
sv/bmd_pkg.sv
sv/bmd_cell.sv
sv/bmd_div.sv
sv/binned_mean_1d.sv
tb/testbench.sv
